/* rtl/core/cbm_pkg.sv */
// shared types, codes and address constants of the cartridge bank mapper
`default_nettype none

package cbm_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ROM_W = 20;
  localparam int unsigned SRAM_W = 14;
  localparam int unsigned TGT_W = 3;
  localparam int unsigned BIG_W = 7;
  localparam int unsigned SMALL_W = 8;

  // result target codes
  localparam logic [TGT_W-1:0] TGT_NONE = 3'd0;
  localparam logic [TGT_W-1:0] TGT_ROM = 3'd1;
  localparam logic [TGT_W-1:0] TGT_SRAM_RD = 3'd2;
  localparam logic [TGT_W-1:0] TGT_SRAM_WR = 3'd3;
  localparam logic [TGT_W-1:0] TGT_REG = 3'd4;

  // bank register write addresses
  localparam logic [ADDR_W-1:0] ADDR_BIG0 = 16'h4fff;
  localparam logic [ADDR_W-1:0] ADDR_BIG1 = 16'h6fff;
  localparam logic [ADDR_W-1:0] ADDR_BIG2 = 16'h8fff;
  localparam logic [ADDR_W-1:0] ADDR_BIG3 = 16'hafff;
  localparam logic [ADDR_W-1:0] ADDR_SMALL0 = 16'h77ff;
  localparam logic [ADDR_W-1:0] ADDR_SMALL1 = 16'h7fff;

  // 8 KB window codes on cpu_addr[15:13]
  localparam logic [2:0] WIN_4000 = 3'b010;
  localparam logic [2:0] WIN_6000 = 3'b011;
  localparam logic [2:0] WIN_8000 = 3'b100;
  localparam logic [2:0] WIN_A000 = 3'b101;

  typedef enum logic [2:0] {
    SEL_BIG0,
    SEL_BIG1,
    SEL_BIG2,
    SEL_BIG3,
    SEL_SMALL0,
    SEL_SMALL1
  } reg_sel_t;

  typedef struct packed {
    logic     en;
    reg_sel_t sel;
  } bank_wr_t;

  typedef struct packed {
    logic [3:0][BIG_W-1:0]   big_bank;
    logic [1:0][SMALL_W-1:0] small_bank;
    logic                    sram_enable;
    logic                    split_window;
  } bank_state_t;

endpackage

`default_nettype wire

/* rtl/core/cbm_bank_regs.sv */
// bank registers and mode flags of the cartridge bank mapper
`default_nettype none

module cbm_bank_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cbm_pkg::bank_wr_t           wr,
  input  wire logic [cbm_pkg::DATA_W-1:0]  wdata,
  output cbm_pkg::bank_state_t             state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (wr.en) begin
      unique case (wr.sel)
        cbm_pkg::SEL_BIG0: begin
          state.big_bank[0] <= wdata[cbm_pkg::BIG_W-1:0];
          state.sram_enable <= wdata[7];
        end
        cbm_pkg::SEL_BIG1: state.big_bank[1] <= wdata[cbm_pkg::BIG_W-1:0];
        cbm_pkg::SEL_BIG2: state.big_bank[2] <= wdata[cbm_pkg::BIG_W-1:0];
        cbm_pkg::SEL_BIG3: begin
          state.big_bank[3] <= wdata[cbm_pkg::BIG_W-1:0];
          state.split_window <= wdata[7];
        end
        cbm_pkg::SEL_SMALL0: state.small_bank[0] <= wdata;
        cbm_pkg::SEL_SMALL1: state.small_bank[1] <= wdata;
        default: ;
      endcase
    end
  end

  a_sram_flag: assert property (@(posedge clk) disable iff (rst)
    wr.en && wr.sel == cbm_pkg::SEL_BIG0 |=> state.sram_enable == $past(wdata[7]))
    else $error("sram enable flag not taken from bank write");

  a_split_flag: assert property (@(posedge clk) disable iff (rst)
    wr.en && wr.sel == cbm_pkg::SEL_BIG3 |=> state.split_window == $past(wdata[7]))
    else $error("split window flag not taken from bank write");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !wr.en |=> $stable(state))
    else $error("bank state changed without a register write");

endmodule

`default_nettype wire

/* rtl/core/cbm_decode.sv */
// address decode and page mapping of one access
`default_nettype none

module cbm_decode (
  input  wire logic                        func,
  input  wire logic [cbm_pkg::ADDR_W-1:0]  cpu_addr,
  input  wire cbm_pkg::bank_state_t        state,
  output logic [cbm_pkg::TGT_W-1:0]        target,
  output logic [cbm_pkg::ROM_W-1:0]        rom_addr,
  output logic [cbm_pkg::SRAM_W-1:0]       sram_addr,
  output cbm_pkg::bank_wr_t                wr
);

  always_comb begin
    target = cbm_pkg::TGT_NONE;
    rom_addr = '0;
    sram_addr = '0;
    wr.en = 1'b0;
    wr.sel = cbm_pkg::SEL_BIG0;
    if (cpu_addr[15:14] == 2'b00) begin
      if (state.sram_enable) begin
        target = func ? cbm_pkg::TGT_SRAM_WR : cbm_pkg::TGT_SRAM_RD;
        sram_addr = cpu_addr[cbm_pkg::SRAM_W-1:0];
      end
    end else if (func) begin
      unique case (cpu_addr)
        cbm_pkg::ADDR_BIG0: begin
          wr.en = 1'b1;
          wr.sel = cbm_pkg::SEL_BIG0;
        end
        cbm_pkg::ADDR_BIG1: begin
          wr.en = 1'b1;
          wr.sel = cbm_pkg::SEL_BIG1;
        end
        cbm_pkg::ADDR_BIG2: begin
          wr.en = 1'b1;
          wr.sel = cbm_pkg::SEL_BIG2;
        end
        cbm_pkg::ADDR_BIG3: begin
          wr.en = 1'b1;
          wr.sel = cbm_pkg::SEL_BIG3;
        end
        cbm_pkg::ADDR_SMALL0: begin
          wr.en = 1'b1;
          wr.sel = cbm_pkg::SEL_SMALL0;
        end
        cbm_pkg::ADDR_SMALL1: begin
          wr.en = 1'b1;
          wr.sel = cbm_pkg::SEL_SMALL1;
        end
        default: ;
      endcase
      if (wr.en) begin
        target = cbm_pkg::TGT_REG;
      end
    end else if (cpu_addr[15:14] != 2'b11) begin
      target = cbm_pkg::TGT_ROM;
      unique case (cpu_addr[15:13])
        cbm_pkg::WIN_4000: rom_addr = {state.big_bank[0], cpu_addr[12:0]};
        cbm_pkg::WIN_6000: begin
          // upper 4 KB splits into two 2 KB pages in the upper ROM half
          if (state.split_window && cpu_addr[12]) begin
            if (cpu_addr[11]) begin
              rom_addr = {1'b1, state.small_bank[1], cpu_addr[10:0]};
            end else begin
              rom_addr = {1'b1, state.small_bank[0], cpu_addr[10:0]};
            end
          end else begin
            rom_addr = {state.big_bank[1], cpu_addr[12:0]};
          end
        end
        cbm_pkg::WIN_8000: rom_addr = {state.big_bank[2], cpu_addr[12:0]};
        cbm_pkg::WIN_A000: rom_addr = {state.big_bank[3], cpu_addr[12:0]};
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cartridge_bank_mapper.sv */
// Cartridge bank mapper: maps processor accesses onto a 1 MB ROM and a 16 KB SRAM.
//
// Input channel (in_valid / in_stall) carries one access item: func (0 read,
// 1 write), cpu_addr and wdata. Output channel (out_valid / out_stall) carries
// one result item per access: target, rom_addr and sram_addr.
// An item is taken into an input register, decoded by one level of logic
// against the bank registers and then lands in the result register, where
// out_valid rises with it. One item per cycle is sustained while the
// receiver does not stall; the bank register update of a write lands at the same
// edge as its result, so the following item already sees it.
// When the receiver stalls with a result held, the whole two-stage pipeline
// holds and in_stall is raised in the same cycle; nothing is dropped.
// Reset (rst, synchronous) empties both stages, clears all bank registers and
// both mode flags (SRAM unmapped, unsplit 8 KB window at 0x6000).
`default_nettype none

module cartridge_bank_mapper (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        func,
  input  wire logic [cbm_pkg::ADDR_W-1:0]  cpu_addr,
  input  wire logic [cbm_pkg::DATA_W-1:0]  wdata,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cbm_pkg::TGT_W-1:0]        target,
  output logic [cbm_pkg::ROM_W-1:0]        rom_addr,
  output logic [cbm_pkg::SRAM_W-1:0]       sram_addr
);

  logic                        adv;
  logic                        s1_valid;
  logic                        s1_func;
  logic [cbm_pkg::ADDR_W-1:0]  s1_addr;
  logic [cbm_pkg::DATA_W-1:0]  s1_wdata;
  logic [cbm_pkg::TGT_W-1:0]   dec_target;
  logic [cbm_pkg::ROM_W-1:0]   dec_rom;
  logic [cbm_pkg::SRAM_W-1:0]  dec_sram;
  cbm_pkg::bank_wr_t           dec_wr;
  cbm_pkg::bank_wr_t           bank_wr;
  cbm_pkg::bank_state_t        state;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      out_valid <= s1_valid;
    end
    if (adv) begin
      s1_func <= func;
      s1_addr <= cpu_addr;
      s1_wdata <= wdata;
      target <= dec_target;
      rom_addr <= dec_rom;
      sram_addr <= dec_sram;
    end
  end

  cbm_decode u_decode (
    .func      (s1_func),
    .cpu_addr  (s1_addr),
    .state     (state),
    .target    (dec_target),
    .rom_addr  (dec_rom),
    .sram_addr (dec_sram),
    .wr        (dec_wr)
  );

  // a register write commits only when its item moves to the result register
  always_comb begin
    bank_wr.en = dec_wr.en && s1_valid && adv;
    bank_wr.sel = dec_wr.sel;
  end

  cbm_bank_regs u_bank_regs (
    .clk   (clk),
    .rst   (rst),
    .wr    (bank_wr),
    .wdata (s1_wdata),
    .state (state)
  );

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_reg_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (target == cbm_pkg::TGT_REG || target == cbm_pkg::TGT_NONE)
    |-> rom_addr == '0 && sram_addr == '0)
    else $error("address fields set on a result without a memory target");

  a_bank_commit: assert property (@(posedge clk) disable iff (rst)
    bank_wr.en |=> out_valid && target == cbm_pkg::TGT_REG)
    else $error("bank write committed without its register result");

endmodule

`default_nettype wire
